### src/pfc_pkg.sv
package pfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);
  localparam int NLANE = 3;
  localparam int DIV_STEPS = 4;

  localparam logic [3:0] FMT_BGRA8 = 4'd0;
  localparam logic [3:0] FMT_ARGB8 = 4'd1;
  localparam logic [3:0] FMT_RGBA8 = 4'd2;
  localparam logic [3:0] FMT_ABGR8 = 4'd3;
  localparam logic [3:0] FMT_R5G6B5 = 4'd4;
  localparam logic [3:0] FMT_B5G6R5 = 4'd5;
  localparam logic [3:0] FMT_R5G5B5A1 = 4'd6;
  localparam logic [3:0] FMT_A1R5G5B5 = 4'd7;
  localparam logic [3:0] FMT_B5G5R5A1 = 4'd8;
  localparam logic [3:0] FMT_A1B5G5R5 = 4'd9;
  localparam logic [3:0] FMT_A8 = 4'd10;

  localparam logic [1:0] ALPHA_IGNORE = 2'd0;
  localparam logic [1:0] ALPHA_STRAIGHT = 2'd1;
  localparam logic [1:0] ALPHA_PREMUL = 2'd2;

  localparam logic [2:0] CFG_SRC_FORMAT = 3'd0;
  localparam logic [2:0] CFG_SRC_ALPHA = 3'd1;
  localparam logic [2:0] CFG_DST_FORMAT = 3'd2;
  localparam logic [2:0] CFG_DST_ALPHA = 3'd3;

  typedef struct packed {
    logic [4:0] sh_r;
    logic [3:0] w_r;
    logic [4:0] sh_g;
    logic [3:0] w_g;
    logic [4:0] sh_b;
    logic [3:0] w_b;
    logic [4:0] sh_a;
    logic [3:0] w_a;
    logic [2:0] nbytes;
    logic       ok;
  } lay_t;

  typedef struct packed {
    logic                               pass;
    logic [31:0]                        word;
    logic [NLANE-1:0][CW-1:0]           c;
    logic [CW-1:0]                      a;
    logic                               div;
    logic [NLANE-1:0]                   sat;
    logic [NLANE-1:0][FRAC_BITS-1:0]    r;
    logic [NLANE-1:0][FRAC_BITS-1:0]    q;
    logic [FRAC_BITS-1:0]               nb;
  } pfc_data_t;

  function automatic lay_t lay_get(logic [3:0] fmt);
    lay_t l;
    case (fmt)
      FMT_BGRA8:    l = '{5'd16, 4'd8, 5'd8,  4'd8, 5'd0,  4'd8, 5'd24, 4'd8, 3'd4, 1'b1};
      FMT_ARGB8:    l = '{5'd8,  4'd8, 5'd16, 4'd8, 5'd24, 4'd8, 5'd0,  4'd8, 3'd4, 1'b1};
      FMT_RGBA8:    l = '{5'd0,  4'd8, 5'd8,  4'd8, 5'd16, 4'd8, 5'd24, 4'd8, 3'd4, 1'b1};
      FMT_ABGR8:    l = '{5'd24, 4'd8, 5'd16, 4'd8, 5'd8,  4'd8, 5'd0,  4'd8, 3'd4, 1'b1};
      FMT_R5G6B5:   l = '{5'd0,  4'd5, 5'd5,  4'd6, 5'd11, 4'd5, 5'd0,  4'd0, 3'd2, 1'b1};
      FMT_B5G6R5:   l = '{5'd11, 4'd5, 5'd5,  4'd6, 5'd0,  4'd5, 5'd0,  4'd0, 3'd2, 1'b1};
      FMT_R5G5B5A1: l = '{5'd0,  4'd5, 5'd5,  4'd5, 5'd10, 4'd5, 5'd15, 4'd1, 3'd2, 1'b1};
      FMT_A1R5G5B5: l = '{5'd1,  4'd5, 5'd6,  4'd5, 5'd11, 4'd5, 5'd0,  4'd1, 3'd2, 1'b1};
      FMT_B5G5R5A1: l = '{5'd10, 4'd5, 5'd5,  4'd5, 5'd0,  4'd5, 5'd15, 4'd1, 3'd2, 1'b1};
      FMT_A1B5G5R5: l = '{5'd11, 4'd5, 5'd6,  4'd5, 5'd1,  4'd5, 5'd0,  4'd1, 3'd2, 1'b1};
      FMT_A8:       l = '{5'd0,  4'd0, 5'd0,  4'd0, 5'd0,  4'd0, 5'd0,  4'd8, 3'd1, 1'b1};
      default:      l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [31:0] byte_mask(logic [2:0] nbytes);
    logic [31:0] m;
    case (nbytes)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0;
    endcase
    return m;
  endfunction

  // round(v * ONE / max) for 1, 5, 6 and 8 bit channels
  function automatic logic [CW-1:0] expand(logic [7:0] v, logic [3:0] w, logic [CW-1:0] dflt);
    logic [CW-1:0] e;
    logic [10:0] x6;
    logic [21:0] p6;
    case (w)
      4'd1: e = v[0] ? ONE : '0;
      4'd5: e = CW'(v[4:0]) * CW'(2114)
                + ((v[4:0] >= 5'd24) ? CW'(2) : (v[4:0] >= 5'd8) ? CW'(1) : CW'(0));
      4'd6: begin
        x6 = {1'b0, v[5:0], 4'b0} + 11'd31;
        p6 = 22'(x6) * 22'd1041;
        e = CW'(v[5:0]) * CW'(1040) + CW'(p6[21:16]);
      end
      4'd8: e = CW'(v) * CW'(257) + CW'(v[7]);
      default: e = dflt;
    endcase
    return e;
  endfunction

  // round(c * max / ONE), clamped to max
  function automatic logic [7:0] pack(logic [CW-1:0] c, logic [3:0] w);
    logic [CW+8:0] p;
    logic [7:0] mx;
    logic [8:0] e;
    case (w)
      4'd1:    mx = 8'd1;
      4'd5:    mx = 8'd31;
      4'd6:    mx = 8'd63;
      4'd8:    mx = 8'd255;
      default: mx = 8'd0;
    endcase
    p = (CW+9)'(c) * (CW+9)'(mx) + (CW+9)'(HALF);
    e = 9'(p >> FRAC_BITS);
    return (e > {1'b0, mx}) ? mx : e[7:0];
  endfunction

endpackage

### src/pfc_div_stage.sv
module pfc_div_stage (
  input  pfc_pkg::pfc_data_t d_in,
  output pfc_pkg::pfc_data_t d_out
);

  always_comb begin
    logic [pfc_pkg::FRAC_BITS:0] t;
    logic [pfc_pkg::FRAC_BITS:0] den;
    d_out = d_in;
    den = {1'b0, d_in.a[pfc_pkg::FRAC_BITS-1:0]};
    for (int s = 0; s < pfc_pkg::DIV_STEPS; s++) begin
      for (int i = 0; i < pfc_pkg::NLANE; i++) begin
        t = {d_out.r[i], d_out.nb[pfc_pkg::FRAC_BITS-1]};
        if (t >= den) begin
          d_out.r[i] = t[pfc_pkg::FRAC_BITS-1:0] - den[pfc_pkg::FRAC_BITS-1:0];
          d_out.q[i] = {d_out.q[i][pfc_pkg::FRAC_BITS-2:0], 1'b1};
        end else begin
          d_out.r[i] = t[pfc_pkg::FRAC_BITS-1:0];
          d_out.q[i] = {d_out.q[i][pfc_pkg::FRAC_BITS-2:0], 1'b0};
        end
      end
      d_out.nb = {d_out.nb[pfc_pkg::FRAC_BITS-2:0], 1'b0};
    end
  end

endmodule

### src/pixel_format_converter_core.sv
// Pixel format converter core.
// Input channel: in_valid / in_ready carry one source pixel word per beat on
// pixel_in, byte 0 in bits 7:0. Output channel: out_valid / out_ready carry
// the converted word on pixel_out, unused upper bytes zero.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 src_format, 1 src_alpha_kind, 2 dst_format, 3 dst_alpha_kind); write
// only while no beat is in flight.
// From input beat to output beat a pixel passes, in order, through decode, four stages of
// the restoring divider (four quotient bits each) used for premultiplied
// sources, target alpha multiply, and encode into the output register.
// Throughput is one beat per cycle while the receiver keeps out_ready high.
// Each stage carries its own valid bit and advances when the stage ahead is
// empty or moving, so a stalled receiver fills the bubbles first and then
// holds in_ready low; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets both formats to bgra8
// with straight alpha.
module pixel_format_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int NST = pfc_pkg::DIV_STEPS + 2;

  logic [3:0] src_format;
  logic [1:0] src_alpha_kind;
  logic [3:0] dst_format;
  logic [1:0] dst_alpha_kind;

  pfc_pkg::pfc_data_t st [NST];
  pfc_pkg::pfc_data_t nxt [NST];
  logic [NST:0] vld;
  logic [NST:0] rdy;
  logic [31:0] out_word;
  logic [31:0] out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_format <= pfc_pkg::FMT_BGRA8;
      src_alpha_kind <= pfc_pkg::ALPHA_STRAIGHT;
      dst_format <= pfc_pkg::FMT_BGRA8;
      dst_alpha_kind <= pfc_pkg::ALPHA_STRAIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::CFG_SRC_FORMAT: src_format <= cfg_data;
        pfc_pkg::CFG_SRC_ALPHA:  src_alpha_kind <= cfg_data[1:0];
        pfc_pkg::CFG_DST_FORMAT: dst_format <= cfg_data;
        pfc_pkg::CFG_DST_ALPHA:  dst_alpha_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // decode
  always_comb begin
    pfc_pkg::lay_t ls;
    logic [pfc_pkg::CW-1:0] a;
    ls = pfc_pkg::lay_get(src_format);
    nxt[0] = '0;
    nxt[0].pass = (src_format == dst_format) && (src_alpha_kind == dst_alpha_kind);
    nxt[0].word = pixel_in & pfc_pkg::byte_mask(ls.nbytes);
    if (ls.ok) begin
      nxt[0].c[0] = pfc_pkg::expand(8'(pixel_in >> ls.sh_r), ls.w_r, '0);
      nxt[0].c[1] = pfc_pkg::expand(8'(pixel_in >> ls.sh_g), ls.w_g, '0);
      nxt[0].c[2] = pfc_pkg::expand(8'(pixel_in >> ls.sh_b), ls.w_b, '0);
      a = pfc_pkg::expand(8'(pixel_in >> ls.sh_a), ls.w_a, pfc_pkg::ONE);
    end else begin
      nxt[0].c = {pfc_pkg::NLANE{pfc_pkg::ONE}};
      a = pfc_pkg::ONE;
    end
    if (src_alpha_kind == pfc_pkg::ALPHA_IGNORE) begin
      a = pfc_pkg::ONE;
    end
    nxt[0].a = a;
    nxt[0].div = (src_alpha_kind == pfc_pkg::ALPHA_PREMUL) && (a != '0) && (a < pfc_pkg::ONE);
    nxt[0].nb = a[pfc_pkg::FRAC_BITS:1];
    for (int i = 0; i < pfc_pkg::NLANE; i++) begin
      nxt[0].sat[i] = nxt[0].c[i] >= a;
      nxt[0].r[i] = nxt[0].c[i][pfc_pkg::FRAC_BITS-1:0];
    end
  end

  for (genvar k = 1; k <= pfc_pkg::DIV_STEPS; k++) begin : g_div
    pfc_div_stage u_div (
      .d_in  (st[k-1]),
      .d_out (nxt[k])
    );
  end

  // quotient select and target alpha
  always_comb begin
    logic [pfc_pkg::CW-1:0] c;
    logic [2*pfc_pkg::CW-1:0] p;
    nxt[NST-1] = st[NST-2];
    nxt[NST-1].div = 1'b0;
    for (int i = 0; i < pfc_pkg::NLANE; i++) begin
      c = st[NST-2].c[i];
      if (st[NST-2].div) begin
        c = st[NST-2].sat[i] ? pfc_pkg::ONE : {1'b0, st[NST-2].q[i]};
      end
      p = (2*pfc_pkg::CW)'(c) * (2*pfc_pkg::CW)'(st[NST-2].a)
          + (2*pfc_pkg::CW)'(pfc_pkg::HALF);
      if (dst_alpha_kind == pfc_pkg::ALPHA_PREMUL && st[NST-2].a < pfc_pkg::ONE) begin
        c = p[pfc_pkg::FRAC_BITS +: pfc_pkg::CW];
      end
      nxt[NST-1].c[i] = c;
    end
    if (dst_alpha_kind == pfc_pkg::ALPHA_IGNORE) begin
      nxt[NST-1].a = pfc_pkg::ONE;
    end
  end

  // encode
  always_comb begin
    pfc_pkg::lay_t ld;
    logic [31:0] res;
    ld = pfc_pkg::lay_get(dst_format);
    res = (32'(pfc_pkg::pack(st[NST-1].c[0], ld.w_r)) << ld.sh_r)
        | (32'(pfc_pkg::pack(st[NST-1].c[1], ld.w_g)) << ld.sh_g)
        | (32'(pfc_pkg::pack(st[NST-1].c[2], ld.w_b)) << ld.sh_b)
        | (32'(pfc_pkg::pack(st[NST-1].a, ld.w_a)) << ld.sh_a);
    res = res & pfc_pkg::byte_mask(ld.nbytes);
    out_next = st[NST-1].pass ? st[NST-1].word : res;
  end

  always_comb begin
    rdy[NST] = !vld[NST] || out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) st[k] <= nxt[k];
    end
    if (rdy[NST]) out_word <= out_next;
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[NST];
  assign pixel_out = out_word;

endmodule

### src/pfc_checker.sv
module pfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] pixel_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [3:0]  cfg_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_out))
    else $error("output payload changed while stalled");

endmodule

bind pixel_format_converter_core pfc_checker u_pfc_checker (.*);

### sim/pixel_format_converter_checker.sv
`timescale 1ns / 1ps
module pixel_format_converter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] pixel_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] pixel_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam longint UNIT = 64'd1 << pfc_pkg::FRAC_BITS;
  localparam longint HALF_UNIT = 64'd1 << (pfc_pkg::FRAC_BITS - 1);

  logic [3:0] src_fmt, dst_fmt;
  logic [1:0] src_mode, dst_mode;
  logic [31:0] expected_words[$];

  // shift and width per channel r, g, b, a, then byte count
  function automatic void layout_of(input logic [3:0] fmt, output int sh[4], output int w[4],
                                    output int nb);
    case (fmt)
      pfc_pkg::FMT_BGRA8:    begin sh = '{16, 8, 0, 24}; w = '{8, 8, 8, 8}; nb = 4; end
      pfc_pkg::FMT_ARGB8:    begin sh = '{8, 16, 24, 0}; w = '{8, 8, 8, 8}; nb = 4; end
      pfc_pkg::FMT_RGBA8:    begin sh = '{0, 8, 16, 24}; w = '{8, 8, 8, 8}; nb = 4; end
      pfc_pkg::FMT_ABGR8:    begin sh = '{24, 16, 8, 0}; w = '{8, 8, 8, 8}; nb = 4; end
      pfc_pkg::FMT_R5G6B5:   begin sh = '{0, 5, 11, 0};  w = '{5, 6, 5, 0}; nb = 2; end
      pfc_pkg::FMT_B5G6R5:   begin sh = '{11, 5, 0, 0};  w = '{5, 6, 5, 0}; nb = 2; end
      pfc_pkg::FMT_R5G5B5A1: begin sh = '{0, 5, 10, 15}; w = '{5, 5, 5, 1}; nb = 2; end
      pfc_pkg::FMT_A1R5G5B5: begin sh = '{1, 6, 11, 0};  w = '{5, 5, 5, 1}; nb = 2; end
      pfc_pkg::FMT_B5G5R5A1: begin sh = '{10, 5, 0, 15}; w = '{5, 5, 5, 1}; nb = 2; end
      pfc_pkg::FMT_A1B5G5R5: begin sh = '{11, 6, 1, 0};  w = '{5, 5, 5, 1}; nb = 2; end
      pfc_pkg::FMT_A8:       begin sh = '{0, 0, 0, 0};   w = '{0, 0, 0, 8}; nb = 1; end
      default:               begin sh = '{0, 0, 0, 0};   w = '{0, 0, 0, 0}; nb = 0; end
    endcase
  endfunction

  function automatic logic [31:0] mask_bytes(int nb);
    return (nb >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
  endfunction

  function automatic logic [31:0] convert_pixel(logic [31:0] pix);
    int sh[4], w[4], nb;
    longint ch[4], mx, v, q, e;
    logic [31:0] res;
    res = '0;
    layout_of(src_fmt, sh, w, nb);
    if (src_fmt == dst_fmt && src_mode == dst_mode) return pix & mask_bytes(nb);
    for (int i = 0; i < 4; i++) begin
      if (src_fmt > pfc_pkg::FMT_A8) ch[i] = UNIT;
      else if (w[i] == 0) ch[i] = (i == 3) ? UNIT : 0;
      else begin
        mx = (64'd1 << w[i]) - 1;
        v = (pix >> sh[i]) & mx;
        ch[i] = (v * UNIT + mx / 2) / mx;
      end
    end
    if (src_mode == pfc_pkg::ALPHA_IGNORE) ch[3] = UNIT;
    else if (src_mode == pfc_pkg::ALPHA_PREMUL && ch[3] > 0 && ch[3] < UNIT)
      for (int i = 0; i < 3; i++) begin
        q = (ch[i] * UNIT + ch[3] / 2) / ch[3];
        ch[i] = (q > UNIT) ? UNIT : q;
      end
    if (dst_mode == pfc_pkg::ALPHA_IGNORE) ch[3] = UNIT;
    else if (dst_mode == pfc_pkg::ALPHA_PREMUL && ch[3] < UNIT)
      for (int i = 0; i < 3; i++)
        ch[i] = (ch[i] * ch[3] + HALF_UNIT) >> pfc_pkg::FRAC_BITS;
    layout_of(dst_fmt, sh, w, nb);
    for (int i = 0; i < 4; i++)
      if (w[i] != 0) begin
        mx = (64'd1 << w[i]) - 1;
        e = (ch[i] * mx + HALF_UNIT) >> pfc_pkg::FRAC_BITS;
        if (e > mx) e = mx;
        res |= 32'(e << sh[i]);
      end
    return res & mask_bytes(nb);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_words.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      src_fmt <= pfc_pkg::FMT_BGRA8;
      dst_fmt <= pfc_pkg::FMT_BGRA8;
      src_mode <= pfc_pkg::ALPHA_STRAIGHT;
      dst_mode <= pfc_pkg::ALPHA_STRAIGHT;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) expected_words.push_back(convert_pixel(pixel_in));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0)
          report_mismatch($sformatf("unexpected beat %h", pixel_out));
        else begin
          want = expected_words.pop_front();
          if (pixel_out !== want)
            report_mismatch($sformatf("pixel_out %h, want %h", pixel_out, want));
        end
      end
      if (cfg_we)
        case (cfg_index)
          pfc_pkg::CFG_SRC_FORMAT: src_fmt <= cfg_data;
          pfc_pkg::CFG_SRC_ALPHA:  src_mode <= cfg_data[1:0];
          pfc_pkg::CFG_DST_FORMAT: dst_fmt <= cfg_data;
          pfc_pkg::CFG_DST_ALPHA:  dst_mode <= cfg_data[1:0];
          default: ;
        endcase
    end
  end

endmodule

### sim/tb_pixel_format_converter_core.sv
`timescale 1ns / 1ps
module tb_pixel_format_converter_core;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] pixel_out;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_off = 0;

  always #5 clk = ~clk;

  pixel_format_converter_core dut (.*);

  pixel_format_converter_checker chk (.*);

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_pixel(input logic [31:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_modes(input logic [3:0] sf, input logic [1:0] sa,
                           input logic [3:0] df, input logic [1:0] da);
    write_reg(pfc_pkg::CFG_SRC_FORMAT, sf);
    write_reg(pfc_pkg::CFG_SRC_ALPHA, {2'b0, sa});
    write_reg(pfc_pkg::CFG_DST_FORMAT, df);
    write_reg(pfc_pkg::CFG_DST_ALPHA, {2'b0, da});
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {8'($urandom_range(255)), 24'h0} | ($urandom() & 32'h00FF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] edge_pix[8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_8000, 32'h7FFF_7FFF,
                                 32'h80FF_4020, 32'h01FF_FF00, 32'h00FF_FFFF, 32'h5555_AAAA};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset setting: passthrough
    foreach (edge_pix[i]) send_pixel(edge_pix[i]);
    drain();
    set_modes(pfc_pkg::FMT_RGBA8, pfc_pkg::ALPHA_PREMUL, pfc_pkg::FMT_A1R5G5B5,
              pfc_pkg::ALPHA_PREMUL);
    foreach (edge_pix[i]) send_pixel(edge_pix[i]);
    drain();
    set_modes(4'd15, 2'd3, pfc_pkg::FMT_A8, pfc_pkg::ALPHA_IGNORE);
    send_pixel(32'h1234_5678);
    drain();
    set_modes(4'd12, pfc_pkg::ALPHA_STRAIGHT, 4'd12, pfc_pkg::ALPHA_STRAIGHT);
    send_pixel(32'hFFFF_FFFF);
    drain();
    set_modes(pfc_pkg::FMT_A8, pfc_pkg::ALPHA_STRAIGHT, 4'd15, pfc_pkg::ALPHA_PREMUL);
    send_pixel(32'hA5A5_A5A5);
    drain();

    for (int ph = 0; ph < 28; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (ph == 0)
        set_modes(pfc_pkg::FMT_BGRA8, pfc_pkg::ALPHA_IGNORE, pfc_pkg::FMT_A8,
                  pfc_pkg::ALPHA_PREMUL);
      else if (ph == 1)
        set_modes(pfc_pkg::FMT_A8, pfc_pkg::ALPHA_PREMUL, pfc_pkg::FMT_BGRA8,
                  pfc_pkg::ALPHA_IGNORE);
      else begin
        logic [1:0] sa, da;
        sa = $urandom_range(3) == 0 ? 2'd3 : 2'($urandom_range(2));
        da = $urandom_range(3) == 0 ? pfc_pkg::ALPHA_PREMUL : 2'($urandom_range(2));
        set_modes($urandom_range(15) == 0 ? 4'd13 : 4'($urandom_range(10)), sa,
                  $urandom_range(15) == 0 ? 4'd11 : 4'($urandom_range(10)), da);
      end
      if (ph == 4) hold_off <= 200;
      for (int n = 0; n < 25; n++) send_pixel(random_pixel());
      if (ph == 6) drain();
      drain();
    end
    drain();
    if (fail_count == 0) $display("** pixel_format_converter_core: PASSED **");
    else $display("** pixel_format_converter_core: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** pixel_format_converter_core: FAILED **");
    $finish;
  end

endmodule

### filelist.f
src/pfc_pkg.sv
src/pfc_div_stage.sv
src/pixel_format_converter_core.sv
src/pfc_checker.sv
sim/pixel_format_converter_checker.sv
sim/tb_pixel_format_converter_core.sv
